// File: rtl/console_audio_channels_defines.svh
// ----------------------------------------------------------------------------
// console_audio_channels_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_AUDIO_CHANNELS_DEFINES_SVH
`define CONSOLE_AUDIO_CHANNELS_DEFINES_SVH

// Implication checked on every clock, held off during reset
`define CAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked on the clock after the antecedent
`define CAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/cac_pkg.sv
// ----------------------------------------------------------------------------
// cac_pkg
// Types, codes and tables shared by the sound unit files.
// ----------------------------------------------------------------------------
package cac_pkg;

    localparam int NumCfg = 5;
    localparam int CfgIdxW = 3;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_DMC   = 2'd3
    } action_t;

    localparam logic [4:0] REG_P1_CTRL  = 5'h00;
    localparam logic [4:0] REG_P1_SWEEP = 5'h01;
    localparam logic [4:0] REG_P1_LO    = 5'h02;
    localparam logic [4:0] REG_P1_HI    = 5'h03;
    localparam logic [4:0] REG_P2_CTRL  = 5'h04;
    localparam logic [4:0] REG_P2_SWEEP = 5'h05;
    localparam logic [4:0] REG_P2_LO    = 5'h06;
    localparam logic [4:0] REG_P2_HI    = 5'h07;
    localparam logic [4:0] REG_TRI_LIN  = 5'h08;
    localparam logic [4:0] REG_TRI_LO   = 5'h0a;
    localparam logic [4:0] REG_TRI_HI   = 5'h0b;
    localparam logic [4:0] REG_NOI_CTRL = 5'h0c;
    localparam logic [4:0] REG_NOI_PER  = 5'h0e;
    localparam logic [4:0] REG_NOI_LEN  = 5'h0f;
    localparam logic [4:0] REG_DMC_FREQ = 5'h10;
    localparam logic [4:0] REG_DMC_RAW  = 5'h11;
    localparam logic [4:0] REG_DMC_ADDR = 5'h12;
    localparam logic [4:0] REG_DMC_LEN  = 5'h13;
    localparam logic [4:0] REG_STATUS   = 5'h15;
    localparam logic [4:0] REG_FRAME    = 5'h17;

    localparam logic [15:0] FrameStep1Rst = 16'd7457;
    localparam logic [15:0] FrameStep2Rst = 16'd14913;
    localparam logic [15:0] FrameStep3Rst = 16'd22371;
    localparam logic [15:0] FrameStep4Rst = 16'd29829;
    localparam logic [15:0] FrameStep5Rst = 16'd37281;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] reg_index;
        logic [7:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  pulse1_level;
        logic [3:0]  pulse2_level;
        logic [3:0]  triangle_level;
        logic [3:0]  noise_level;
        logic [6:0]  dmc_level;
        logic [7:0]  read_data;
        logic        frame_irq;
        logic        dmc_request;
        logic [15:0] dmc_address;
    } out_item_t;

    typedef struct packed {
        logic start, halt, constant;
        logic [3:0] volume, decay, divider;
    } env_t;

    // events a pulse channel gets from the top level
    typedef struct packed {
        logic       tick;
        logic       quarter;
        logic       half;
        logic       wr;
        logic [1:0] wr_reg;
        logic [7:0] wr_data;
        logic       en_wr;
        logic       en_val;
    } pulse_ctl_t;

    function automatic logic [7:0] len_lookup(input logic [4:0] i);
        logic [7:0] r;
        unique case (i)
            5'd0: r = 8'd10;   5'd1: r = 8'd254;  5'd2: r = 8'd20;   5'd3: r = 8'd2;
            5'd4: r = 8'd40;   5'd5: r = 8'd4;    5'd6: r = 8'd80;   5'd7: r = 8'd6;
            5'd8: r = 8'd160;  5'd9: r = 8'd8;    5'd10: r = 8'd60;  5'd11: r = 8'd10;
            5'd12: r = 8'd14;  5'd13: r = 8'd12;  5'd14: r = 8'd26;  5'd15: r = 8'd14;
            5'd16: r = 8'd12;  5'd17: r = 8'd16;  5'd18: r = 8'd24;  5'd19: r = 8'd18;
            5'd20: r = 8'd48;  5'd21: r = 8'd20;  5'd22: r = 8'd96;  5'd23: r = 8'd22;
            5'd24: r = 8'd192; 5'd25: r = 8'd24;  5'd26: r = 8'd72;  5'd27: r = 8'd26;
            5'd28: r = 8'd16;  5'd29: r = 8'd28;  5'd30: r = 8'd32;  default: r = 8'd30;
        endcase
        return r;
    endfunction

    function automatic logic [11:0] noise_period(input logic [3:0] i);
        logic [11:0] r;
        unique case (i)
            4'd0: r = 12'd4;     4'd1: r = 12'd8;     4'd2: r = 12'd16;    4'd3: r = 12'd32;
            4'd4: r = 12'd64;    4'd5: r = 12'd96;    4'd6: r = 12'd128;   4'd7: r = 12'd160;
            4'd8: r = 12'd202;   4'd9: r = 12'd254;   4'd10: r = 12'd380;  4'd11: r = 12'd508;
            4'd12: r = 12'd762;  4'd13: r = 12'd1016; 4'd14: r = 12'd2034; default: r = 12'd4068;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] dmc_period(input logic [3:0] i);
        logic [8:0] r;
        unique case (i)
            4'd0: r = 9'd428;  4'd1: r = 9'd380;  4'd2: r = 9'd340;  4'd3: r = 9'd320;
            4'd4: r = 9'd286;  4'd5: r = 9'd254;  4'd6: r = 9'd226;  4'd7: r = 9'd214;
            4'd8: r = 9'd190;  4'd9: r = 9'd160;  4'd10: r = 9'd142; 4'd11: r = 9'd128;
            4'd12: r = 9'd106; 4'd13: r = 9'd84;  4'd14: r = 9'd72;  default: r = 9'd54;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] duty_lookup(input logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0: r = 8'h02;
            2'd1: r = 8'h06;
            2'd2: r = 8'h1e;
            default: r = 8'hf9;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] tri_lookup(input logic [4:0] s);
        return s[4] ? s[3:0] : ~s[3:0];
    endfunction

    function automatic env_t env_clock(input env_t e);
        env_t r;
        r = e;
        if (e.start) begin
            r.start = 1'b0;
            r.decay = 4'd15;
            r.divider = e.volume;
        end else if (e.divider != 4'd0) begin
            r.divider = e.divider - 4'd1;
        end else begin
            r.divider = e.volume;
            if (e.decay != 4'd0) r.decay = e.decay - 4'd1;
            else if (e.halt) r.decay = 4'd15;
        end
        return r;
    endfunction

    function automatic logic [3:0] env_level(input env_t e);
        return e.constant ? e.volume : e.decay;
    endfunction

endpackage

// File: rtl/console_audio_channels.sv
// ----------------------------------------------------------------------------
// console_audio_channels
// Five-channel console sound unit with frame sequencer and DMC fetch request.
// ----------------------------------------------------------------------------
// One beat per clock: each accepted item (tick, register write, status read
// or DMC byte) updates the channel state in the cycle it is accepted and its
// result lands in the output register on the same edge, so the block takes
// an item every cycle while the output side keeps up. The output register
// holds one result; in_ready falls only while that result is unclaimed and
// out_ready is low. frame_step registers should be written while idle.
module console_audio_channels import cac_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [15:0]        cfg_data
);

    logic [15:0] step_reg [NumCfg];
    logic        acc;
    logic        is_tick, is_wr, is_rd, is_status_rd;
    logic [4:0]  ri;
    logic [7:0]  wd;
    logic        quarter, half, frame_end, even;

    logic [15:0] fc_reg, fc_next;
    logic        five_reg, five_next, irq_en_reg, irq_en_next, irq_reg, irq_next;

    // triangle
    logic        t_ctrl_reg, t_ctrl_next, t_rf_reg, t_rf_next, t_en_reg, t_en_next;
    logic [6:0]  t_lrl_reg, t_lrl_next, t_lin_reg, t_lin_next;
    logic [7:0]  t_len_reg, t_len_next;
    logic [4:0]  t_seq_reg, t_seq_next;
    logic [10:0] t_per_reg, t_per_next, t_val_reg, t_val_next;

    // noise
    env_t        n_env_reg, n_env_next;
    logic        n_mode_reg, n_mode_next, n_en_reg, n_en_next;
    logic [7:0]  n_len_reg, n_len_next;
    logic [11:0] n_per_reg, n_per_next, n_val_reg, n_val_next;
    logic [14:0] n_sh_reg, n_sh_next;

    // dmc
    logic        d_en_reg, d_en_next;
    logic [6:0]  d_out_reg, d_out_next;
    logic [7:0]  d_buf_reg, d_buf_next;
    logic [3:0]  d_bits_reg, d_bits_next;
    logic [8:0]  d_per_reg, d_per_next, d_val_reg, d_val_next;
    logic [15:0] d_addr_reg, d_addr_next;
    logic [11:0] d_len_reg, d_len_next;
    logic        req;
    logic [15:0] req_addr;

    pulse_ctl_t  p1_ctl, p2_ctl;
    logic [3:0]  p1_lvl, p2_lvl;
    logic        p1_nz, p2_nz;
    logic        fb;
    logic [7:0]  rd;
    out_item_t   res;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    assign cfg_ready = 1'b1;
    assign in_ready = !out_valid_reg || out_ready;
    assign acc = in_valid && in_ready;
    assign ri = in_data.reg_index;
    assign wd = in_data.write_data;
    assign is_tick = acc && in_data.action == ACT_TICK;
    assign is_wr = acc && in_data.action == ACT_WRITE;
    assign is_rd = acc && in_data.action == ACT_READ;
    assign is_status_rd = is_rd && ri == REG_STATUS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg[0] <= FrameStep1Rst;
            step_reg[1] <= FrameStep2Rst;
            step_reg[2] <= FrameStep3Rst;
            step_reg[3] <= FrameStep4Rst;
            step_reg[4] <= FrameStep5Rst;
        end else if (cfg_valid) begin
            for (int i = 0; i < NumCfg; i++)
                if (cfg_index == CfgIdxW'(i)) step_reg[i] <= cfg_data;
        end
    end

    assign even = !fc_reg[0];
    assign quarter = is_tick && (fc_reg == step_reg[0] || fc_reg == step_reg[1]
                     || fc_reg == step_reg[2] || fc_reg == step_reg[3]);
    assign half = is_tick && (fc_reg == step_reg[0] || fc_reg == step_reg[2]);
    assign frame_end = fc_reg == (five_reg ? step_reg[4] : step_reg[3]);

    always_comb
    begin
        p1_ctl = '0;
        p1_ctl.tick = is_tick && even;
        p1_ctl.quarter = quarter;
        p1_ctl.half = half;
        p1_ctl.wr = is_wr && ri[4:2] == 3'd0;
        p1_ctl.wr_reg = ri[1:0];
        p1_ctl.wr_data = wd;
        p1_ctl.en_wr = is_wr && ri == REG_STATUS;
        p1_ctl.en_val = wd[0];
        p2_ctl = p1_ctl;
        p2_ctl.wr = is_wr && ri[4:2] == 3'd1;
        p2_ctl.en_val = wd[1];
    end

    cac_pulse #(.ONES_NEG(1'b1)) u_pulse1 (
        .clk(clk), .rst_n(rst_n), .ctl(p1_ctl), .level(p1_lvl), .length_nz(p1_nz)
    );
    cac_pulse #(.ONES_NEG(1'b0)) u_pulse2 (
        .clk(clk), .rst_n(rst_n), .ctl(p2_ctl), .level(p2_lvl), .length_nz(p2_nz)
    );

    always_comb
    begin
        fc_next = fc_reg; five_next = five_reg; irq_en_next = irq_en_reg; irq_next = irq_reg;
        t_ctrl_next = t_ctrl_reg; t_rf_next = t_rf_reg; t_en_next = t_en_reg;
        t_lrl_next = t_lrl_reg; t_lin_next = t_lin_reg; t_len_next = t_len_reg;
        t_seq_next = t_seq_reg; t_per_next = t_per_reg; t_val_next = t_val_reg;
        n_env_next = n_env_reg; n_mode_next = n_mode_reg; n_en_next = n_en_reg;
        n_len_next = n_len_reg; n_per_next = n_per_reg; n_val_next = n_val_reg;
        n_sh_next = n_sh_reg;
        d_en_next = d_en_reg; d_out_next = d_out_reg; d_buf_next = d_buf_reg;
        d_bits_next = d_bits_reg; d_per_next = d_per_reg; d_val_next = d_val_reg;
        d_addr_next = d_addr_reg; d_len_next = d_len_reg;
        req = 1'b0; req_addr = 16'd0;
        fb = 1'b0;
        rd = 8'd0;

        if (is_tick) begin
            if (t_val_reg == 11'd0) begin
                t_val_next = t_per_reg;
                if (t_len_reg != 8'd0 && t_lin_reg != 7'd0 && t_per_reg > 11'd2)
                    t_seq_next = t_seq_reg + 5'd1;
            end else begin
                t_val_next = t_val_reg - 11'd1;
            end
            if (even) begin
                if (n_val_reg != 12'd0) begin
                    n_val_next = n_val_reg - 12'd1;
                end else begin
                    n_val_next = n_per_reg;
                    fb = n_sh_reg[0] ^ (n_mode_reg ? n_sh_reg[6] : n_sh_reg[1]);
                    n_sh_next = {fb, n_sh_reg[14:1]};
                end
                if (d_en_reg) begin
                    if (d_val_reg != 9'd0) begin
                        d_val_next = d_val_reg - 9'd1;
                    end else begin
                        d_val_next = d_per_reg;
                        if (d_bits_reg != 4'd0) begin
                            d_buf_next = d_buf_reg >> 1;
                            d_bits_next = d_bits_reg - 4'd1;
                            if (d_buf_reg[0] && d_out_reg <= 7'd125)
                                d_out_next = d_out_reg + 7'd2;
                            if (!d_buf_reg[0] && d_out_reg >= 7'd2)
                                d_out_next = d_out_reg - 7'd2;
                        end
                        if (d_bits_next == 4'd0 && d_len_reg != 12'd0) begin
                            d_len_next = d_len_reg - 12'd1;
                            req = 1'b1;
                            req_addr = d_addr_reg | 16'h8000;
                            d_buf_next = 8'd0;
                            d_bits_next = 4'd8;
                            d_addr_next = d_addr_reg + 16'd1;
                        end
                    end
                end
            end
            if (quarter) begin
                if (t_rf_reg) t_lin_next = t_lrl_reg;
                else if (t_lin_reg != 7'd0) t_lin_next = t_lin_reg - 7'd1;
                if (!t_ctrl_reg) t_rf_next = 1'b0;
                n_env_next = env_clock(n_env_reg);
            end
            if (half) begin
                if (t_len_reg != 8'd0 && !t_ctrl_reg) t_len_next = t_len_reg - 8'd1;
                if (n_len_reg != 8'd0 && !n_env_reg.halt) n_len_next = n_len_reg - 8'd1;
            end
            if (frame_end) begin
                if (irq_en_reg) irq_next = 1'b1;
                fc_next = 16'd0;
            end else begin
                fc_next = fc_reg + 16'd1;
            end
        end

        if (is_wr) begin
            unique case (ri)
                REG_TRI_LIN: begin
                    t_ctrl_next = wd[7];
                    t_lrl_next = wd[6:0];
                end
                REG_TRI_LO: t_per_next = {t_per_reg[10:8], wd};
                REG_TRI_HI: begin
                    t_per_next = {wd[2:0], t_per_reg[7:0]};
                    if (t_en_reg) t_len_next = len_lookup(wd[7:3]);
                    t_rf_next = 1'b1;
                end
                REG_NOI_CTRL: begin
                    n_env_next.halt = wd[5];
                    n_env_next.constant = wd[4];
                    n_env_next.volume = wd[3:0];
                end
                REG_NOI_PER: begin
                    n_mode_next = wd[7];
                    n_per_next = noise_period(wd[3:0]);
                end
                REG_NOI_LEN: begin
                    if (n_en_reg) n_len_next = len_lookup(wd[7:3]);
                    n_env_next.start = 1'b1;
                end
                REG_DMC_FREQ: d_per_next = dmc_period(wd[3:0]);
                REG_DMC_RAW: d_out_next = wd[6:0];
                REG_DMC_ADDR: d_addr_next = {2'b11, wd, 6'd0};
                REG_DMC_LEN: d_len_next = {wd, 4'd1};
                REG_STATUS: begin
                    t_en_next = wd[2];
                    if (!wd[2]) t_len_next = 8'd0;
                    n_en_next = wd[3];
                    if (!wd[3]) n_len_next = 8'd0;
                    d_en_next = wd[4];
                end
                REG_FRAME: begin
                    if (wd[6]) irq_next = 1'b0;
                    five_next = wd[7];
                    irq_en_next = wd[7:6] == 2'b00;
                    fc_next = 16'd0;
                end
                default: ;
            endcase
        end

        if (is_status_rd) begin
            rd = {3'd0, d_en_reg, n_len_reg != 8'd0, t_len_reg != 8'd0, p2_nz, p1_nz};
            irq_next = 1'b0;
        end

        if (acc && in_data.action == ACT_DMC) d_buf_next = wd;
    end

    // result fields read the state being committed on this edge
    always_comb
    begin
        res = '0;
        res.pulse1_level = 4'd0;
        res.triangle_level = tri_lookup(t_seq_next);
        res.noise_level = (!n_en_next || n_sh_next[0] || n_len_next == 8'd0)
                          ? 4'd0 : env_level(n_env_next);
        res.dmc_level = d_out_next;
        res.read_data = rd;
        res.frame_irq = irq_next;
        res.dmc_request = req;
        res.dmc_address = req_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fc_reg <= '0; five_reg <= 1'b0; irq_en_reg <= 1'b0; irq_reg <= 1'b0;
            t_ctrl_reg <= 1'b0; t_rf_reg <= 1'b0; t_en_reg <= 1'b0; t_lrl_reg <= '0;
            t_lin_reg <= '0; t_len_reg <= '0; t_seq_reg <= '0; t_per_reg <= '0;
            t_val_reg <= '0;
            n_env_reg <= '0; n_mode_reg <= 1'b0; n_en_reg <= 1'b0; n_len_reg <= '0;
            n_per_reg <= '0; n_val_reg <= '0; n_sh_reg <= 15'd1;
            d_en_reg <= 1'b0; d_out_reg <= '0; d_buf_reg <= '0; d_bits_reg <= '0;
            d_per_reg <= '0; d_val_reg <= '0; d_addr_reg <= '0; d_len_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            fc_reg <= fc_next; five_reg <= five_next; irq_en_reg <= irq_en_next;
            irq_reg <= irq_next;
            t_ctrl_reg <= t_ctrl_next; t_rf_reg <= t_rf_next; t_en_reg <= t_en_next;
            t_lrl_reg <= t_lrl_next; t_lin_reg <= t_lin_next; t_len_reg <= t_len_next;
            t_seq_reg <= t_seq_next; t_per_reg <= t_per_next; t_val_reg <= t_val_next;
            n_env_reg <= n_env_next; n_mode_reg <= n_mode_next; n_en_reg <= n_en_next;
            n_len_reg <= n_len_next; n_per_reg <= n_per_next; n_val_reg <= n_val_next;
            n_sh_reg <= n_sh_next;
            d_en_reg <= d_en_next; d_out_reg <= d_out_next; d_buf_reg <= d_buf_next;
            d_bits_reg <= d_bits_next; d_per_reg <= d_per_next; d_val_reg <= d_val_next;
            d_addr_reg <= d_addr_next; d_len_reg <= d_len_next;
            if (acc) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // pulse levels come from the channel registers once they have taken this
    // edge's update, so they are merged at the output rather than captured here
    logic pend_reg;
    always_ff @(posedge clk)
    begin
        if (acc) out_data_reg <= res;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) pend_reg <= 1'b0;
        else if (acc) pend_reg <= 1'b1;
        else if (out_ready) pend_reg <= 1'b0;
    end

    always_comb
    begin
        out_data = out_data_reg;
        out_data.pulse1_level = p1_lvl;
        out_data.pulse2_level = p2_lvl;
    end
    assign out_valid = out_valid_reg && pend_reg;

endmodule

// File: rtl/cac_pulse.sv
// ----------------------------------------------------------------------------
// cac_pulse
// One pulse channel: duty sequencer, envelope, sweep and length counter.
// ----------------------------------------------------------------------------
module cac_pulse import cac_pkg::*; #(
    parameter bit ONES_NEG = 1'b1
) (
    input  logic       clk,
    input  logic       rst_n,
    input  pulse_ctl_t ctl,
    output logic [3:0] level,
    output logic       length_nz
);

    logic [7:0]  duty_reg, duty_next;
    env_t        env_reg, env_next;
    logic        sw_en_reg, sw_en_next, sw_neg_reg, sw_neg_next, sw_rld_reg, sw_rld_next;
    logic [2:0]  sw_per_reg, sw_per_next, sw_shift_reg, sw_shift_next;
    logic [2:0]  sw_val_reg, sw_val_next;
    logic [10:0] period_reg, period_next, timer_reg, timer_next;
    logic [2:0]  seq_reg, seq_next;
    logic [7:0]  len_reg, len_next;
    logic        en_reg, en_next;
    logic [15:0] target_cur;

    function automatic logic [15:0] calc_target(input logic [10:0] p, input logic [2:0] sh,
                                                input logic ng);
        logic [15:0] pw, d;
        pw = {5'd0, p};
        d = pw >> sh;
        if (ng) return pw - d - (ONES_NEG ? 16'd1 : 16'd0);
        return pw + d;
    endfunction

    // target is always a function of current period/shift/negate
    assign target_cur = calc_target(period_reg, sw_shift_reg, sw_neg_reg);

    always_comb
    begin
        duty_next = duty_reg; env_next = env_reg;
        sw_en_next = sw_en_reg; sw_neg_next = sw_neg_reg; sw_rld_next = sw_rld_reg;
        sw_per_next = sw_per_reg; sw_shift_next = sw_shift_reg; sw_val_next = sw_val_reg;
        period_next = period_reg; timer_next = timer_reg; seq_next = seq_reg;
        len_next = len_reg; en_next = en_reg;
        if (ctl.tick) begin
            if (timer_reg == 11'd0) begin
                timer_next = period_reg;
                seq_next = seq_reg + 3'd1;
            end else begin
                timer_next = timer_reg - 11'd1;
            end
        end
        if (ctl.quarter) env_next = env_clock(env_reg);
        if (ctl.half) begin
            if (sw_en_reg && sw_val_reg == 3'd0 && sw_shift_reg != 3'd0
                && target_cur[15:11] == 5'd0)
                period_next = target_cur[10:0];
            if (sw_val_reg == 3'd0 || sw_rld_reg) begin
                sw_val_next = sw_per_reg;
                sw_rld_next = 1'b0;
            end else begin
                sw_val_next = sw_val_reg - 3'd1;
            end
            if (len_reg != 8'd0 && !env_reg.halt) len_next = len_reg - 8'd1;
        end
        if (ctl.wr) begin
            unique case (ctl.wr_reg)
                2'd0: begin
                    duty_next = duty_lookup(ctl.wr_data[7:6]);
                    env_next.halt = ctl.wr_data[5];
                    env_next.constant = ctl.wr_data[4];
                    env_next.volume = ctl.wr_data[3:0];
                end
                2'd1: begin
                    sw_en_next = ctl.wr_data[7];
                    sw_per_next = ctl.wr_data[6:4];
                    sw_neg_next = ctl.wr_data[3];
                    sw_shift_next = ctl.wr_data[2:0];
                    sw_rld_next = 1'b1;
                end
                2'd2: period_next = {period_reg[10:8], ctl.wr_data};
                default: begin
                    period_next = {ctl.wr_data[2:0], period_reg[7:0]};
                    seq_next = 3'd0;
                    if (en_reg) len_next = len_lookup(ctl.wr_data[7:3]);
                    env_next.start = 1'b1;
                end
            endcase
        end
        if (ctl.en_wr) begin
            en_next = ctl.en_val;
            if (!ctl.en_val) len_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            duty_reg <= '0; env_reg <= '0; sw_en_reg <= 1'b0; sw_neg_reg <= 1'b0;
            sw_rld_reg <= 1'b0; sw_per_reg <= '0; sw_shift_reg <= '0; sw_val_reg <= '0;
            period_reg <= '0; timer_reg <= '0; seq_reg <= '0; len_reg <= '0; en_reg <= 1'b0;
        end else begin
            duty_reg <= duty_next; env_reg <= env_next; sw_en_reg <= sw_en_next;
            sw_neg_reg <= sw_neg_next; sw_rld_reg <= sw_rld_next; sw_per_reg <= sw_per_next;
            sw_shift_reg <= sw_shift_next; sw_val_reg <= sw_val_next;
            period_reg <= period_next; timer_reg <= timer_next; seq_reg <= seq_next;
            len_reg <= len_next; en_reg <= en_next;
        end
    end

    assign length_nz = len_reg != 8'd0;
    assign level = (!en_reg || period_reg < 11'd8 || len_reg == 8'd0
                    || target_cur[15:11] != 5'd0 || !duty_reg[seq_reg])
                   ? 4'd0 : env_level(env_reg);

endmodule

// File: rtl/cac_checker.sv
// ----------------------------------------------------------------------------
// cac_checker
// Port-level checks on the sound unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "console_audio_channels_defines.svh"

module cac_checker import cac_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // a held result stays put
    `CAC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, $stable(out_data))
    // every accepted item yields a result next cycle
    `CAC_ASSERT_NXT(a_acc_res, clk, rst_n, in_valid && in_ready, out_valid)
    // no address without a request
    `CAC_ASSERT_IMP(a_addr, clk, rst_n, out_valid && !out_data.dmc_request,
                    out_data.dmc_address == 16'd0)
    // requested addresses sit in the upper half
    `CAC_ASSERT_IMP(a_addr_hi, clk, rst_n, out_valid && out_data.dmc_request,
                    out_data.dmc_address[15])
    // read_data top bits are always zero on a valid result
    `CAC_ASSERT_IMP(a_rd_top, clk, rst_n, out_valid, out_data.read_data[7:5] == 3'd0)

endmodule

bind console_audio_channels cac_checker u_cac_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
